FILE: rtl/tic_pkg.sv
`default_nettype none

package tic_pkg;

	// Result status codes.
	localparam logic [1:0] STATUS_RECORDED = 2'd0;
	localparam logic [1:0] STATUS_REJECTED = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PLAYER_COUNT  = 3'd0;
	localparam logic [2:0] CFG_LOCAL_PLAYER  = 3'd1;
	localparam logic [2:0] CFG_INPUT_DELAY   = 3'd2;
	localparam logic [2:0] CFG_PREDICT_LIMIT = 3'd3;
	localparam logic [2:0] CFG_LOCKSTEP_MODE = 3'd4;

	localparam logic [7:0] PREDICT_LIMIT_RESET = 8'd15;

	typedef struct packed {
		logic        is_local;
		logic [2:0]  sender;
		logic [31:0] report_tick;
		logic [31:0] sim_tick;
	} tic_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] execution_tick;
		logic [31:0] confirmed_tick;
		logic        may_advance;
	} tic_result_t;

endpackage

`default_nettype wire

FILE: rtl/tick_input_confirmation_window_core.sv
`default_nettype none

// Channel   Handshake            Payload          Notes
// input     start / busy         item             taken when start=1 and busy=0
// result    done (one cycle)     result           receiver cannot stall
// config    cfg_wen              cfg_idx, cfg_wdata  taken on any edge with cfg_wen=1
//
// A rejected or out-of-window item goes from evaluate straight to the result
// state. A recorded item is merged and then scanned, where every confirmed
// entry costs one read and one check of the mask memory, which has one read
// and one write port. The result strobe rises in the same cycle as busy falls.
// After reset the mask memory is cleared one entry per cycle, which holds
// busy high until every entry is cleared; configuration writes are taken meanwhile.
// Results are shown for one cycle only and are never held back.

module tick_input_confirmation_window_core #(
	parameter int WINDOW_TICKS = 64,
	parameter int MAX_PLAYERS  = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire tic_pkg::tic_item_t  item,
	output logic                     done,
	output tic_pkg::tic_result_t     result,
	input  wire logic                cfg_wen,
	input  wire logic [2:0]          cfg_idx,
	input  wire logic [7:0]          cfg_wdata
);

	import tic_pkg::*;

	localparam int AW = $clog2(WINDOW_TICKS);
	localparam int NW = $clog2(MAX_PLAYERS + 1);
	localparam int MW = MAX_PLAYERS;

	// The sequencer walks one item through evaluate and, if it is recorded, merge and the
	// confirmation scan, sharing the mask memory's read and write ports between them.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_MERGE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RESP
	} state_t;

	state_t      state_q;
	logic [31:0] cp_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] clr_q;
	logic        done_q;

	// Configuration registers.
	logic [3:0] player_count_q;
	logic [2:0] local_id_q;
	logic [7:0] delay_q;
	logic [7:0] limit_q;
	logic       lockstep_q;

	// Per-item working registers.
	logic [31:0] sim_q;
	logic [31:0] exec_q;
	logic        ok_q;
	logic [2:0]  player_q;
	logic [AW-1:0] slot_q;
	logic [1:0]  status_q;
	tic_result_t result_q;

	// Memory port.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [MW-1:0] rd_data;

	logic          accept;
	logic [NW-1:0] n_act;
	logic [MW-1:0] need;
	logic [MW-1:0] player_bit;
	logic [2:0]    acc_player;
	logic          acc_ok;
	logic [31:0]   tick_gap;
	logic          outside;
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] head_next;
	logic          entry_full;
	logic          may;

	assign accept = start && (state_q == ST_IDLE);

	// Player count zero counts as one player; counts above the maximum saturate.
	always_comb begin
		if (player_count_q == 4'd0) begin
			n_act = NW'(1);
		end else if (32'(player_count_q) > MAX_PLAYERS) begin
			n_act = NW'(MAX_PLAYERS);
		end else begin
			n_act = NW'(player_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MW; i++) begin
			need[i] = (32'(i) < 32'(n_act));
		end
	end

	// A local report records the local player; a remote one must come from
	// another active player.
	always_comb begin
		if (item.is_local) begin
			acc_player = local_id_q;
			acc_ok     = 32'(local_id_q) < 32'(n_act);
		end else begin
			acc_player = item.sender;
			acc_ok     = (32'(item.sender) < 32'(n_act)) && (item.sender != local_id_q);
		end
	end

	// Distance from the confirmed tick, taken modulo 2^32.
	assign tick_gap = exec_q - cp_q;
	assign outside  = tick_gap >= 32'(WINDOW_TICKS);
	assign slot_sum = {1'b0, head_q} + {1'b0, tick_gap[AW-1:0]};
	assign slot     = (slot_sum >= (AW+1)'(WINDOW_TICKS)) ?
	                  AW'(slot_sum - (AW+1)'(WINDOW_TICKS)) : slot_sum[AW-1:0];
	assign head_next  = (head_q == AW'(WINDOW_TICKS - 1)) ? '0 : head_q + AW'(1);
	assign player_bit = MW'(1) << player_q;
	// Bits of players that are no longer active are ignored here.
	assign entry_full = (rd_data & need) == need;

	// Speculative mode compares against confirmed plus limit without wrapping.
	assign may = lockstep_q ? (sim_q < cp_q) :
	             ({1'b0, sim_q} <= ({1'b0, cp_q} + 33'(limit_q)));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_EVAL: begin
				rd_en   = 1'b1;
				rd_addr = slot;
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = rd_data | player_bit;
			end
			ST_SCAN_RD: begin
				rd_en = 1'b1;
			end
			ST_SCAN_CHK: begin
				// A confirmed entry is cleared as the pointer passes it.
				wr_en = entry_full;
			end
			default: begin
			end
		endcase
	end

	tic_mask_ram #(
		.DEPTH(WINDOW_TICKS),
		.WIDTH(MW)
	) u_mask_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cp_q           <= '0;
			head_q         <= '0;
			clr_q          <= '0;
			done_q         <= 1'b0;
			player_count_q <= 4'd1;
			local_id_q     <= 3'd0;
			delay_q        <= 8'd0;
			limit_q        <= PREDICT_LIMIT_RESET;
			lockstep_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wen) begin
				case (cfg_idx)
					CFG_PLAYER_COUNT:  player_count_q <= cfg_wdata[3:0];
					CFG_LOCAL_PLAYER:  local_id_q     <= cfg_wdata[2:0];
					CFG_INPUT_DELAY:   delay_q        <= cfg_wdata;
					CFG_PREDICT_LIMIT: limit_q        <= cfg_wdata;
					CFG_LOCKSTEP_MODE: lockstep_q     <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= (clr_q == AW'(WINDOW_TICKS - 1)) ? '0 : clr_q + AW'(1);
					if (clr_q == AW'(WINDOW_TICKS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!ok_q || outside) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (entry_full) begin
						head_q  <= head_next;
						cp_q    <= cp_q + 32'd1;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and result registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			sim_q    <= item.sim_tick;
			player_q <= acc_player;
			ok_q     <= acc_ok;
			exec_q   <= acc_ok && item.is_local ?
			            item.report_tick + 32'(delay_q) : item.report_tick;
		end
		if (state_q == ST_EVAL) begin
			slot_q <= slot;
			if (!ok_q) begin
				status_q <= STATUS_REJECTED;
			end else if (outside) begin
				status_q <= STATUS_OUTSIDE;
			end else begin
				status_q <= STATUS_RECORDED;
			end
		end
		if (state_q == ST_RESP) begin
			result_q.status         <= status_q;
			result_q.execution_tick <= exec_q;
			result_q.confirmed_tick <= cp_q;
			result_q.may_advance    <= may;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/tic_mask_ram.sv
`default_nettype none

module tic_mask_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; a write in the previous cycle is seen.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tic_checker.sv
`default_nettype none

module tic_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// An accepted item makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted item");

	// A result only ever closes a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy period");

	// One result per item: strobes never come back to back.
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// No result appears in the cycle right after an accept.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result too early after an accepted item");

endmodule

bind tick_input_confirmation_window_core tic_checker u_tic_checker (.*);

`default_nettype wire
